[rtl/core/pnve_pkg.sv]
// Shared constants and control types for the polygon nearest vertex/edge search.
package pnve_pkg;

    localparam int MaxVertices = 64;
    localparam int AddrW       = $clog2(MaxVertices);
    localparam int CountW      = AddrW + 1;
    localparam int DivSteps    = 52;
    localparam int DivCntW     = 6;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_OVF   = 2'd2;

    localparam logic [25:0] RADIUS_RESET = 26'd2500;

    // controller to datapath
    typedef struct packed {
        logic              clear;
        logic              append;
        logic              load_q;
        logic              rd_en;
        logic [AddrW-1:0]  rd_addr;
        logic              vtx;
        logic              first;
        logic              edge_ld;
        logic              fin_ld;
        logic              e1;
        logic              e2;
        logic              e3;
        logic              div_start;
        logic              div_step;
        logic              cmp;
        logic              out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CountW-1:0] count;
        logic              skip;
        logic              need_div;
    } t_sts;

endpackage

[rtl/core/pnve_if.sv]
// Valid/ready channel interfaces for input words and result words.
interface pnve_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic signed [11:0] point_x;
    logic signed [11:0] point_y;
    modport source (output valid, output cmd, output point_x, output point_y, input ready);
    modport sink   (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

interface pnve_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               vertex_found;
    logic [5:0]         vertex_index;
    logic               edge_found;
    logic [5:0]         edge_index;
    logic signed [11:0] edge_start_x;
    logic signed [11:0] edge_start_y;
    logic signed [11:0] edge_end_x;
    logic signed [11:0] edge_end_y;
    modport source (output valid, output status, output vertex_found, output vertex_index,
                    output edge_found, output edge_index, output edge_start_x,
                    output edge_start_y, output edge_end_x, output edge_end_y, input ready);
    modport sink   (input valid, input status, input vertex_found, input vertex_index,
                    input edge_found, input edge_index, input edge_start_x,
                    input edge_start_y, input edge_end_x, input edge_end_y, output ready);
endinterface

[rtl/core/pnve_dp.sv]
// Datapath: vertex store, distance arithmetic, serial divider and best-so-far registers.
module pnve_dp
    import pnve_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic signed [11:0] i_px,
    input  logic signed [11:0] i_py,
    input  logic               i_cfg_we,
    input  logic [25:0]        i_cfg_wdata,
    output logic [25:0]        o_radius,
    output logic [1:0]         o_status,
    output logic               o_vertex_found,
    output logic [5:0]         o_vertex_index,
    output logic               o_edge_found,
    output logic [5:0]         o_edge_index,
    output logic signed [11:0] o_edge_start_x,
    output logic signed [11:0] o_edge_start_y,
    output logic signed [11:0] o_edge_end_x,
    output logic signed [11:0] o_edge_end_y
);

    logic [23:0] mem [MaxVertices];

    logic [CountW-1:0] r_count;
    logic              r_ovf;
    logic [25:0]       r_radius;

    logic signed [11:0] r_qx, r_qy;
    logic [23:0]        r_rdata, r_v0, r_prev, r_a, r_b;
    logic [AddrW-1:0]   r_cur_e;
    logic               r_empty;

    logic [25:0]        r_vbest;
    logic               r_vfound;
    logic [AddrW-1:0]   r_vidx;

    logic signed [12:0] r_dx, r_dy, r_wx, r_wy, r_ux, r_uy;
    logic [25:0]        r_len2, r_da, r_db;
    logic signed [26:0] r_dot, r_cross;
    logic [25:0]        r_cand;
    logic [26:0]        r_rem;
    logic [51:0]        r_quo;
    logic               r_from_div;

    logic               r_efound;
    logic [25:0]        r_ebest;
    logic [AddrW-1:0]   r_eidx;
    logic [23:0]        r_ea, r_eb;

    logic               r_skip, r_need_div;

    // vertex distance
    logic signed [12:0] vdx, vdy;
    logic [25:0]        vdist;
    assign vdx   = {r_qx[11], r_qx} - {r_rdata[23], r_rdata[23:12]};
    assign vdy   = {r_qy[11], r_qy} - {r_rdata[11], r_rdata[11:0]};
    assign vdist = 26'(vdx * vdx) + 26'(vdy * vdy);

    logic [25:0]        abs_cross;
    assign abs_cross = r_cross[26] ? 26'(-r_cross) : r_cross[25:0];

    logic [26:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {r_rem[25:0], r_quo[51]};
    assign rem_ge = rem_sh >= {1'b0, r_len2};

    logic [25:0] cand_sel;
    assign cand_sel = r_from_div ? r_quo[25:0] : r_cand;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < CountW'(MaxVertices))) begin
            mem[r_count[AddrW-1:0]] <= {i_px, i_py};
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.append) begin
                if (r_count < CountW'(MaxVertices)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q) begin
            r_qx     <= i_px;
            r_qy     <= i_py;
            r_vbest  <= r_radius;
            r_vfound <= 1'b0;
            r_vidx   <= '0;
            r_efound <= 1'b0;
            r_empty  <= (r_count == '0);
        end
        if (i_cmd.vtx) begin
            r_prev <= r_rdata;
            if (vdist < r_vbest) begin
                r_vbest  <= vdist;
                r_vfound <= 1'b1;
                r_vidx   <= i_cmd.rd_addr;
            end
        end
        if (i_cmd.first) begin
            r_v0 <= r_rdata;
        end
        if (i_cmd.edge_ld) begin
            r_a     <= r_prev;
            r_b     <= r_rdata;
            r_cur_e <= i_cmd.rd_addr - 1'b1;
        end
        if (i_cmd.fin_ld) begin
            r_a     <= r_prev;
            r_b     <= r_v0;
            r_cur_e <= AddrW'(r_count - 1'b1);
        end
        if (i_cmd.e1) begin
            r_dx <= {r_b[23], r_b[23:12]} - {r_a[23], r_a[23:12]};
            r_dy <= {r_b[11], r_b[11:0]} - {r_a[11], r_a[11:0]};
            r_wx <= {r_qx[11], r_qx} - {r_a[23], r_a[23:12]};
            r_wy <= {r_qy[11], r_qy} - {r_a[11], r_a[11:0]};
            r_ux <= {r_qx[11], r_qx} - {r_b[23], r_b[23:12]};
            r_uy <= {r_qy[11], r_qy} - {r_b[11], r_b[11:0]};
        end
        if (i_cmd.e2) begin
            r_len2  <= 26'(r_dx * r_dx) + 26'(r_dy * r_dy);
            r_dot   <= 27'(r_wx * r_dx) + 27'(r_wy * r_dy);
            r_cross <= 27'(r_wx * r_dy) - 27'(r_wy * r_dx);
            r_da    <= 26'(r_wx * r_wx) + 26'(r_wy * r_wy);
            r_db    <= 26'(r_ux * r_ux) + 26'(r_uy * r_uy);
        end
        if (i_cmd.e3) begin
            r_skip     <= (r_len2 == '0);
            r_need_div <= 1'b0;
            r_from_div <= 1'b0;
            if (r_dot[26] || (r_dot == '0)) begin
                r_cand <= r_da;
            end else if (r_dot >= $signed({1'b0, r_len2})) begin
                r_cand <= r_db;
            end else begin
                r_need_div <= 1'b1;
                r_quo      <= abs_cross * abs_cross;
            end
        end
        if (i_cmd.div_start) begin
            r_rem      <= '0;
            r_from_div <= 1'b1;
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sh - {1'b0, r_len2} : rem_sh;
            r_quo <= {r_quo[50:0], rem_ge};
        end
        if (i_cmd.cmp) begin
            if (!r_efound || (cand_sel < r_ebest)) begin
                r_efound <= 1'b1;
                r_ebest  <= cand_sel;
                r_eidx   <= r_cur_e;
                r_ea     <= r_a;
                r_eb     <= r_b;
            end
        end
        if (i_cmd.out_load) begin
            o_status       <= r_empty ? STATUS_EMPTY : (r_ovf ? STATUS_OVF : STATUS_OK);
            o_vertex_found <= !r_empty && r_vfound;
            o_vertex_index <= (!r_empty && r_vfound) ? 6'(r_vidx) : '0;
            o_edge_found   <= !r_empty && r_efound;
            o_edge_index   <= (!r_empty && r_efound) ? 6'(r_eidx) : '0;
            o_edge_start_x <= (!r_empty && r_efound) ? r_ea[23:12] : '0;
            o_edge_start_y <= (!r_empty && r_efound) ? r_ea[11:0] : '0;
            o_edge_end_x   <= (!r_empty && r_efound) ? r_eb[23:12] : '0;
            o_edge_end_y   <= (!r_empty && r_efound) ? r_eb[11:0] : '0;
        end
    end

    assign o_sts.count    = r_count;
    assign o_sts.skip     = r_skip;
    assign o_sts.need_div = r_need_div;
    assign o_radius       = r_radius;

endmodule

[rtl/core/pnve_ctrl.sv]
// Controller: walks the vertex store for one query and sequences the edge arithmetic.
module pnve_ctrl
    import pnve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_VTX  = 4'd2;
    localparam logic [3:0] S_FIN  = 4'd3;
    localparam logic [3:0] S_E1   = 4'd4;
    localparam logic [3:0] S_E2   = 4'd5;
    localparam logic [3:0] S_E3   = 4'd6;
    localparam logic [3:0] S_DIVS = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;
    localparam logic [3:0] S_NEXT = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [CountW-1:0] r_k, n_k;
    logic              r_final, n_final;
    logic [DivCntW-1:0] r_dcnt, n_dcnt;
    logic              r_ovalid, n_ovalid;

    logic accept, last_k;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign last_k     = (r_k + 1'b1 == i_sts.count);
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_final  = r_final;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.rd_addr = r_k[AddrW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_cmd)
                        CMD_CLEAR:  o_cmd.clear  = 1'b1;
                        CMD_APPEND: o_cmd.append = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.load_q = 1'b1;
                            n_k     = '0;
                            n_final = 1'b0;
                            n_state = (i_sts.count == '0) ? S_DONE : S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_VTX;
            end
            S_VTX: begin
                o_cmd.vtx = 1'b1;
                if (r_k == '0) begin
                    o_cmd.first = 1'b1;
                    n_state = S_NEXT;
                end else begin
                    o_cmd.edge_ld = 1'b1;
                    n_state = S_E1;
                end
            end
            S_FIN: begin
                o_cmd.fin_ld = 1'b1;
                n_final = 1'b1;
                n_state = S_E1;
            end
            S_E1: begin
                o_cmd.e1 = 1'b1;
                n_state = S_E2;
            end
            S_E2: begin
                o_cmd.e2 = 1'b1;
                n_state = S_E3;
            end
            S_E3: begin
                o_cmd.e3 = 1'b1;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                // zero-length edge is skipped, clamped ends go straight to compare
                if (i_sts.skip) begin
                    n_state = S_NEXT;
                end else if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DivCntW'(DivSteps - 1)) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (r_final) begin
                    n_state = S_DONE;
                end else if (last_k) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_RD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_final  <= 1'b0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_final  <= n_final;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

[rtl/core/polygon_nearest_vertex_edge.sv]
// Top level of the polygon nearest vertex and nearest edge search.
// Clear and append words are taken in the idle state and leave the controller there.
// A query walks the stored vertices one per memory read. A zero-length edge is skipped
// before the compare. When the point projects inside the edge, the squared cross
// product must be divided by the squared length in the bit-serial divider. A finished
// query waits while the previous result still sits unread in the output register.
// The result sits in that register, so a new word is taken while a result
// still waits.
module polygon_nearest_vertex_edge
    import pnve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnve_in_if.sink     in_ch,
    pnve_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd        cmd;
    t_sts        sts;
    logic [25:0] radius;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
    assign prdata = (paddr == 2'd0) ? {6'd0, radius} : 32'd0;

    pnve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_cmd    (in_ch.cmd),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pnve_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_px           (in_ch.point_x),
        .i_py           (in_ch.point_y),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (pwdata[25:0]),
        .o_radius       (radius),
        .o_status       (out_ch.status),
        .o_vertex_found (out_ch.vertex_found),
        .o_vertex_index (out_ch.vertex_index),
        .o_edge_found   (out_ch.edge_found),
        .o_edge_index   (out_ch.edge_index),
        .o_edge_start_x (out_ch.edge_start_x),
        .o_edge_start_y (out_ch.edge_start_y),
        .o_edge_end_x   (out_ch.edge_end_x),
        .o_edge_end_y   (out_ch.edge_end_y)
    );

endmodule

[tb/polygon_nearest_vertex_edge_chk.sv]
// Checker: watches both word channels and the register port, predicts and compares results.
module polygon_nearest_vertex_edge_chk
    import pnve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    pnve_in_if          in_ch,
    pnve_out_if         out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ADDR_RADIUS = 2'd0;

    typedef struct packed {
        logic [1:0]         status;
        logic               vertex_found;
        logic [5:0]         vertex_index;
        logic               edge_found;
        logic [5:0]         edge_index;
        logic signed [11:0] start_x;
        logic signed [11:0] start_y;
        logic signed [11:0] end_x;
        logic signed [11:0] end_y;
    } t_hit;

    logic signed [11:0] poly_x [MaxVertices];
    logic signed [11:0] poly_y [MaxVertices];
    int                 poly_count;
    logic               dropped;
    logic [25:0]        radius_sq;
    t_hit               hit_queue [$];
    int                 mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = hit_queue.size();

    function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function automatic t_hit nearest_search(logic signed [11:0] px, logic signed [11:0] py);
        t_hit   r;
        longint dx, dy, wx, wy, len2, dot, cr, d, vbest, ebest;
        int     e;
        bit     efound;
        r      = '0;
        efound = 0;
        ebest  = 0;
        if (poly_count == 0) begin
            r.status = STATUS_EMPTY;
            return r;
        end
        vbest = radius_sq;
        for (int k = 0; k < poly_count; k++) begin
            d = dist_sq(px, py, poly_x[k], poly_y[k]);
            if (d < vbest) begin
                vbest          = d;
                r.vertex_found = 1'b1;
                r.vertex_index = 6'(k);
            end
        end
        for (int k = 0; k < poly_count; k++) begin
            e    = (k + 1 == poly_count) ? 0 : k + 1;
            dx   = longint'(poly_x[e]) - poly_x[k];
            dy   = longint'(poly_y[e]) - poly_y[k];
            wx   = longint'(px) - poly_x[k];
            wy   = longint'(py) - poly_y[k];
            len2 = dx * dx + dy * dy;
            if (len2 != 0) begin
                dot = wx * dx + wy * dy;
                if (dot <= 0) begin
                    d = dist_sq(px, py, poly_x[k], poly_y[k]);
                end else if (dot >= len2) begin
                    d = dist_sq(px, py, poly_x[e], poly_y[e]);
                end else begin
                    cr = wx * dy - wy * dx;
                    d  = (cr * cr) / len2;
                end
                if (!efound || d < ebest) begin
                    ebest        = d;
                    efound       = 1;
                    r.edge_index = 6'(k);
                end
            end
        end
        r.status = dropped ? STATUS_OVF : STATUS_OK;
        if (efound) begin
            e            = (int'(r.edge_index) + 1 == poly_count) ? 0 : r.edge_index + 1;
            r.edge_found = 1'b1;
            r.start_x    = poly_x[r.edge_index];
            r.start_y    = poly_y[r.edge_index];
            r.end_x      = poly_x[e];
            r.end_y      = poly_y[e];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hit got, exp_hit;
        if (!i_rst_n) begin
            poly_count = 0;
            dropped    = 0;
            radius_sq  = RADIUS_RESET;
            hit_queue.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RADIUS)
                radius_sq = pwdata[25:0];
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.cmd)
                    CMD_CLEAR: begin
                        poly_count = 0;
                        dropped    = 0;
                    end
                    CMD_APPEND: begin
                        if (poly_count < MaxVertices) begin
                            poly_x[poly_count] = in_ch.point_x;
                            poly_y[poly_count] = in_ch.point_y;
                            poly_count++;
                        end else begin
                            dropped = 1;
                        end
                    end
                    CMD_QUERY: hit_queue = {hit_queue,
                                            nearest_search(in_ch.point_x, in_ch.point_y)};
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.status, out_ch.vertex_found, out_ch.vertex_index,
                        out_ch.edge_found, out_ch.edge_index, out_ch.edge_start_x,
                        out_ch.edge_start_y, out_ch.edge_end_x, out_ch.edge_end_y};
                if (hit_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result word %p", got);
                end else begin
                    exp_hit = hit_queue.pop_front();
                    if (got !== exp_hit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     exp_hit, got);
                    end
                end
            end
        end
    end
endmodule

[tb/polygon_nearest_vertex_edge_tb.sv]
// Testbench top: drives words and register writes, gives the verdict.
module polygon_nearest_vertex_edge_tb;
    import pnve_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [1:0] ADDR_RADIUS = 2'd0;
    localparam int         STALL_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, quiet_cycles;
    bit          burst;

    pnve_in_if  in_ch ();
    pnve_out_if out_ch ();

    polygon_nearest_vertex_edge u_top (
        .i_clk, .i_rst_n, .in_ch, .out_ch,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    polygon_nearest_vertex_edge_chk u_chk (
        .i_clk, .i_rst_n, .in_ch, .out_ch,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side stalls
    initial begin
        logic v;
        out_ch.ready = 0;
        forever begin
            if (!burst) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(0, 10)) @(posedge i_clk);
            end
            out_ch.ready <= 1;
            do begin
                @(negedge i_clk);
                v = out_ch.valid;
                @(posedge i_clk);
            end while (!v);
        end
    end

    task automatic send_word(logic [1:0] cmd, logic signed [11:0] x, logic signed [11:0] y);
        logic r;
        if (!burst) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(0, 10)) @(posedge i_clk);
        end
        in_ch.valid   <= 1;
        in_ch.cmd     <= cmd;
        in_ch.point_x <= x;
        in_ch.point_y <= y;
        do begin
            @(negedge i_clk);
            r = in_ch.ready;
            @(posedge i_clk);
        end while (!r);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // clears and appends carry no result word
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [25:0] value);
        drain();
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= ADDR_RADIUS;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel    <= 0;
        penable <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [11:0] near_coord(int c, int spread);
        int v;
        v = c + $urandom_range(0, 2 * spread) - spread;
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return 12'(v);
    endfunction

    task automatic random_phase(int n_vert, int n_query);
        int cx, cy, spread;
        cx     = $urandom_range(0, 4095) - 2048;
        cy     = $urandom_range(0, 4095) - 2048;
        spread = $urandom_range(0, 3) == 0 ? 2048 : $urandom_range(1, 200);
        send_word(CMD_CLEAR, 12'($urandom), 12'($urandom));
        for (int k = 0; k < n_vert; k++)
            send_word(CMD_APPEND, near_coord(cx, spread), near_coord(cy, spread));
        for (int q = 0; q < n_query; q++) begin
            case ($urandom_range(0, 9))
                0: send_word(CMD_QUERY, 12'($urandom), 12'($urandom));
                1: send_word(CMD_SPARE, 12'($urandom), 12'($urandom));
                2: send_word(CMD_APPEND, near_coord(cx, spread), near_coord(cy, spread));
                default: send_word(CMD_QUERY, near_coord(cx, spread + 60),
                                   near_coord(cy, spread + 60));
            endcase
        end
    endtask

    initial begin
        logic [25:0] radii [6];
        i_rst_n       = 0;
        burst         = 0;
        psel          = 0;
        penable       = 0;
        pwrite        = 0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 0;
        in_ch.cmd     = CMD_CLEAR;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty store, lone vertex, zero-length edges, extremes, spare code
        send_word(CMD_QUERY, 12'sd0, 12'sd0);
        send_word(CMD_SPARE, 12'sd5, 12'sd5);
        send_word(CMD_APPEND, 12'sd5, 12'sd5);
        send_word(CMD_QUERY, 12'sd5, 12'sd5);
        send_word(CMD_APPEND, 12'sd5, 12'sd5);
        send_word(CMD_QUERY, 12'sd40, 12'sd0);
        send_word(CMD_APPEND, -12'sd2048, -12'sd2048);
        send_word(CMD_APPEND, 12'sd2047, 12'sd2047);
        send_word(CMD_QUERY, 12'sd2047, -12'sd2048);
        send_word(CMD_QUERY, 12'sd100, 12'sd0);
        send_word(CMD_QUERY, 12'sd2047, 12'sd2047);
        send_word(CMD_APPEND, 12'sd2047, -12'sd2048);
        send_word(CMD_QUERY, -12'sd2048, 12'sd2047);
        send_word(CMD_QUERY, 12'sd3, 12'sd7);
        send_word(CMD_CLEAR, 12'sd0, 12'sd0);
        send_word(CMD_QUERY, 12'sd0, 12'sd0);

        radii = '{26'd0, 26'd33554432, 26'd1, 26'($urandom_range(0, 33554432)),
                  26'd2500, 26'($urandom_range(100, 20000))};
        foreach (radii[p]) begin
            write_radius(radii[p]);
            burst = (p == 2);
            random_phase($urandom_range(1, 8), 4);
            if (p == 3) begin
                // fill past capacity; status must show dropped appends until cleared
                random_phase(MaxVertices + 2, 2);
                send_word(CMD_CLEAR, 12'sd0, 12'sd0);
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
